FILE: rtl/soqcc_pkg.sv
package soqcc_pkg;

    // Request kinds carried in the slave-side tuser.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_CHECK = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Answer codes for a received operation.
    localparam logic [1:0] ACT_CONC = 2'd0;
    localparam logic [1:0] ACT_DONE = 2'd1;
    localparam logic [1:0] ACT_ROLL = 2'd2;

    // Area domains with a special meaning.
    localparam logic [2:0] DOM_ALL  = 3'd0;
    localparam logic [2:0] DOM_ATTR = 3'd1;
    localparam logic [2:0] DOM_PIX  = 3'd2;

    localparam int unsigned MSG_TAG_W = 32;
    localparam int unsigned COUNT_OUT_W = 7;

    // Affected area of one operation, lowest field last.
    typedef struct packed {
        logic        [15:0] rect_h;
        logic        [15:0] rect_w;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_x;
        logic        [15:0] layer_id;
        logic        [2:0]  area_domain;
    } t_area;

    localparam int unsigned AREA_W = $bits(t_area);

    // Slave-side tdata layout.
    typedef struct packed {
        logic [4:0]           pad;
        t_area                area;
        logic [MSG_TAG_W-1:0] msg_tag;
        logic [7:0]           origin_id;
    } t_s_data;

    // Master-side tdata layout.
    typedef struct packed {
        logic [5:0]             pad;
        logic [COUNT_OUT_W-1:0] pending_count;
        logic                   dropped;
        logic [1:0]             action;
    } t_m_data;

endpackage

FILE: rtl/soqcc_ram.sv
module soqcc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/soqcc_conflict.sv
module soqcc_conflict (
    input  soqcc_pkg::t_area i_req,
    input  soqcc_pkg::t_area i_entry,
    output logic             o_conflict
);
    import soqcc_pkg::*;

    logic signed [17:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic               meet;
    logic               concurrent;

    // Half-open rectangles; ends need two extra bits to hold x + w.
    always_comb begin
        ax0 = 18'(i_req.rect_x);
        ay0 = 18'(i_req.rect_y);
        bx0 = 18'(i_entry.rect_x);
        by0 = 18'(i_entry.rect_y);
        ax1 = ax0 + $signed({2'b00, i_req.rect_w});
        ay1 = ay0 + $signed({2'b00, i_req.rect_h});
        bx1 = bx0 + $signed({2'b00, i_entry.rect_w});
        by1 = by0 + $signed({2'b00, i_entry.rect_h});

        meet = (i_req.rect_w != '0) && (i_req.rect_h != '0)
            && (i_entry.rect_w != '0) && (i_entry.rect_h != '0)
            && (ax0 < bx1) && (bx0 < ax1) && (ay0 < by1) && (by0 < ay1);

        if ((i_req.area_domain == DOM_ALL) || (i_entry.area_domain == DOM_ALL)) begin
            concurrent = 1'b0;
        end else begin
            concurrent = (i_req.area_domain == DOM_ATTR)
                || (i_req.area_domain != i_entry.area_domain)
                || (i_req.layer_id != i_entry.layer_id)
                || ((i_req.area_domain == DOM_PIX) && !meet);
        end
    end

    assign o_conflict = !concurrent;

endmodule

FILE: rtl/speculative_op_queue_conflict_check.sv
// Add, clear, unused requests and a check on an empty queue load the output register at the
// input transfer, so the result is offered from the next cycle; the next item is taken as it leaves.
// A check on a non-empty queue walks the queued entries (up to QUEUE_DEPTH) in order, one entry
// per cycle through one RAM read port, and then loads the output register, which is always
// empty by then.
// Synchronous active-low reset empties the queue and the output register, not the entry RAM.
module speculative_op_queue_conflict_check #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned TAG_WIDTH   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: origin_id[7:0], msg_tag[39:8], area_domain[42:40], layer_id[58:43],
    //        rect_x[74:59], rect_y[90:75], rect_w[106:91], rect_h[122:107], zero pad
    input  soqcc_pkg::t_s_data   s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]           s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: action[1:0], dropped[2], pending_count[9:3], zero pad
    output soqcc_pkg::t_m_data   m_tdata
);
    import soqcc_pkg::*;

    // Only the low TAG_WIDTH bits of the 32-bit tag take part in the compare.
    localparam int unsigned TW = (TAG_WIDTH < MSG_TAG_W) ? TAG_WIDTH : MSG_TAG_W;
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = AREA_W + TW + 8;

    // The sequencer: idle, compare against the head entry, walk the rest
    // of the queue, and hand the answer to the output register.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic [PW-1:0]   r_idx, n_idx;
    logic [1:0]      r_act, n_act;
    logic [7:0]      r_origin, n_origin;
    logic [TW-1:0]   r_tag, n_tag;
    t_area           r_area, n_area;
    logic            r_out_valid, n_out_valid;
    t_m_data         r_out, n_out;

    logic            ram_we;
    logic [PW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;
    logic [7:0]      ent_origin;
    logic [TW-1:0]   ent_tag;
    t_area           ent_area;
    logic            conflict;
    logic            s_xfer;
    logic            out_free;
    logic            last_entry;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        next_pos = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Entry word: origin in the low byte, then the tag, then the area.
    assign ram_wdata  = {s_tdata.area, s_tdata.msg_tag[TW-1:0], s_tdata.origin_id};
    assign ent_origin = ram_rdata[7:0];
    assign ent_tag    = ram_rdata[8 +: TW];
    assign ent_area   = t_area'(ram_rdata[8 + TW +: AREA_W]);

    soqcc_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one shared area compare, fed with the latched request and the entry just read.
    soqcc_conflict u_conflict (
        .i_req      (r_area),
        .i_entry    (ent_area),
        .o_conflict (conflict)
    );

    // The output register may be loaded when it is empty or being emptied this cycle.
    assign out_free   = !r_out_valid || m_tready;
    assign s_tready   = (r_state == ST_IDLE) && out_free;
    assign s_xfer     = s_tvalid && s_tready;
    // The idle read fetches the head, so it is ready the cycle after a check arrives.
    assign ram_raddr  = (r_state == ST_IDLE) ? r_head : r_ptr;
    assign last_entry = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_act       = r_act;
        n_origin    = r_origin;
        n_tag       = r_tag;
        n_area      = r_area;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_origin = s_tdata.origin_id;
                    n_tag    = s_tdata.msg_tag[TW-1:0];
                    n_area   = s_tdata.area;
                    n_out    = '0;
                    n_out.action = ACT_CONC;
                    case (s_tuser)
                        REQ_ADD: begin
                            n_out_valid = 1'b1;
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_out.dropped = 1'b1;
                            end else begin
                                ram_we  = 1'b1;
                                n_tail  = next_pos(r_tail);
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_CHECK: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_ptr   = next_pos(r_head);
                                n_idx   = '0;
                                n_state = ST_HEAD;
                            end
                        end
                        REQ_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_head      = '0;
                            n_tail      = '0;
                            n_count     = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_out.pending_count = COUNT_OUT_W'(n_count);
                end
            end
            ST_HEAD: begin
                if (ent_origin == r_origin) begin
                    // Our own operation came back: either it is the head, or the queue is stale.
                    n_state = ST_FIN;
                    if (ent_tag == r_tag) begin
                        n_head  = next_pos(r_head);
                        n_count = r_count - CW'(1);
                        n_act   = ACT_DONE;
                    end else begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_act   = ACT_ROLL;
                    end
                end else if (conflict) begin
                    n_act   = ACT_ROLL;
                    n_state = ST_FIN;
                end else if (last_entry) begin
                    n_act   = ACT_CONC;
                    n_state = ST_FIN;
                end else begin
                    n_ptr   = next_pos(r_ptr);
                    n_idx   = r_idx + PW'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The entry at queue position r_idx is on the RAM output now.
                if (conflict) begin
                    n_act   = ACT_ROLL;
                    n_state = ST_FIN;
                end else if (last_entry) begin
                    n_act   = ACT_CONC;
                    n_state = ST_FIN;
                end else begin
                    n_ptr = next_pos(r_ptr);
                    n_idx = r_idx + PW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out               = '0;
                    n_out.action        = r_act;
                    n_out.pending_count = COUNT_OUT_W'(r_count);
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_act    <= n_act;
        r_origin <= n_origin;
        r_tag    <= n_tag;
        r_area   <= n_area;
        r_out    <= n_out;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptrs_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(QUEUE_DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail apart on an empty or full queue");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx != '0 && CW'(r_idx) < r_count))
        else $error("scan index outside the queued entries");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_tready)
        else $error("request taken while a check is running");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (m_tvalid && r_state == ST_IDLE))
        else $error("finished check not handed to the output");

endmodule

FILE: dv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import soqcc_pkg::*;

    // The block is built with its default sizes, and the expectations below assume them.
    localparam int unsigned QUEUE_SLOTS = 64;

    // The one request code the block answers without doing anything.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Expected contents of one result transfer, field by field.
    typedef struct packed {
        logic [1:0]             action;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] pending_count;
    } t_answer;

    // One locally issued operation as the queue holds it.
    typedef struct packed {
        logic [7:0]           origin;
        logic [MSG_TAG_W-1:0] tag;
        t_area                area;
    } t_held_op;

    // A request waiting to be sent, together with the answer it must get.
    // When hold_for_idle is set, the sender keeps it back until every earlier
    // answer has come out of the block.
    typedef struct {
        logic [1:0] kind;
        t_s_data    data;
        t_answer    answer;
        bit         hold_for_idle;
    } t_request;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     s_tvalid = 1'b0;
    logic     s_tready;
    t_s_data  s_tdata  = '0;  // origin_id, msg_tag, area_domain, layer_id, rect_x..rect_h, pad
    logic [1:0] s_tuser = REQ_ADD;  // req_type
    logic     m_tvalid;
    logic     m_tready = 1'b0;
    t_m_data  m_tdata;        // action, dropped, pending_count, pad

    // Shadow of the operation queue, advanced as requests are generated.
    // Requests go out in the order they are generated, so the answer computed
    // here is the one the block must give for that request.
    t_held_op local_ops[$];

    t_request request_backlog[$];
    t_answer  expected_answers[$];

    bit req_taken;
    int accepted_reqs;
    int result_count;
    int fail_count;
    int posted_reqs;
    bit hold_next_for_idle;

    // Sender burst shaping.
    int burst_left;
    int gap_left;

    // Receiver stall shaping, including one long hold-off.
    int  hold_left;
    bit  held_once;
    int  pattern_cycle;
    int  ready_mode;

    speculative_op_queue_conflict_check #(
        .QUEUE_DEPTH(QUEUE_SLOTS),
        .TAG_WIDTH  (MSG_TAG_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Reset is held from the start and released on a falling edge.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // True when an incoming area conflicts with a queued one. The everything
    // domain conflicts with all areas. Otherwise the areas are independent when
    // the incoming one touches only user attributes, when the domains or layers
    // differ, or when both are pixel areas whose half-open rectangles do not
    // overlap. Two equal domains other than pixel or attribute on one layer always conflict.
    function automatic bit areas_clash(t_area mine, t_area theirs);
        int mx0, mx1, my0, my1, tx0, tx1, ty0, ty1;
        if (mine.area_domain == DOM_ALL || theirs.area_domain == DOM_ALL) begin
            return 1'b1;
        end
        if (mine.area_domain == DOM_ATTR || mine.area_domain != theirs.area_domain ||
            mine.layer_id != theirs.layer_id) begin
            return 1'b0;
        end
        if (mine.area_domain != DOM_PIX) begin
            return 1'b1;
        end
        if (mine.rect_w == 0 || mine.rect_h == 0 || theirs.rect_w == 0 || theirs.rect_h == 0) begin
            return 1'b0;
        end
        mx0 = $signed(mine.rect_x);
        my0 = $signed(mine.rect_y);
        tx0 = $signed(theirs.rect_x);
        ty0 = $signed(theirs.rect_y);
        mx1 = mx0 + int'(mine.rect_w);
        my1 = my0 + int'(mine.rect_h);
        tx1 = tx0 + int'(theirs.rect_w);
        ty1 = ty0 + int'(theirs.rect_h);
        return (mx0 < tx1) && (tx0 < mx1) && (my0 < ty1) && (ty0 < my1);
    endfunction

    // Applies one request to the shadow queue and returns the answer it earns.
    function automatic t_answer resolve_request(logic [1:0] kind, t_s_data req);
        t_answer  ans;
        t_held_op op;
        ans = '0;
        ans.action = ACT_CONC;
        case (kind)
            REQ_ADD: begin
                if (local_ops.size() >= QUEUE_SLOTS) begin
                    ans.dropped = 1'b1;
                end else begin
                    op.origin = req.origin_id;
                    op.tag    = req.msg_tag;
                    op.area   = req.area;
                    local_ops.push_back(op);
                end
            end
            REQ_CHECK: begin
                if (local_ops.size() == 0) begin
                    ans.action = ACT_CONC;
                end else if (req.origin_id == local_ops[0].origin) begin
                    // Our own operation coming back: either it is the one we
                    // sent first, or our view has diverged and must be redone.
                    if (req.msg_tag == local_ops[0].tag) begin
                        void'(local_ops.pop_front());
                        ans.action = ACT_DONE;
                    end else begin
                        local_ops.delete();
                        ans.action = ACT_ROLL;
                    end
                end else begin
                    foreach (local_ops[i]) begin
                        if (areas_clash(req.area, local_ops[i].area)) begin
                            ans.action = ACT_ROLL;
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                local_ops.delete();
            end
            default: begin
            end
        endcase
        ans.pending_count = COUNT_OUT_W'(local_ops.size());
        return ans;
    endfunction

    function automatic t_area area_of(logic [2:0] dom, int layer, int x, int y, int w, int h);
        t_area a;
        a.area_domain = dom;
        a.layer_id    = layer[15:0];
        a.rect_x      = x[15:0];
        a.rect_y      = y[15:0];
        a.rect_w      = w[15:0];
        a.rect_h      = h[15:0];
        return a;
    endfunction

    // Random area, biased toward a few layers and small, nearby rectangles so
    // that overlaps and near misses are common; full-range values still appear.
    function automatic t_area random_area();
        t_area a;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            a.area_domain = DOM_ALL;
        end else if (r < 25) begin
            a.area_domain = DOM_ATTR;
        end else if (r < 75) begin
            a.area_domain = DOM_PIX;
        end else begin
            a.area_domain = 3'($urandom_range(3, 7));
        end
        a.layer_id = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        a.rect_x = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 64) - 32) : 16'($urandom);
        a.rect_y = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 64) - 32) : 16'($urandom);
        r = $urandom_range(0, 19);
        a.rect_w = (r < 2) ? 16'd0 : (r < 15) ? 16'($urandom_range(1, 40)) : 16'($urandom);
        r = $urandom_range(0, 19);
        a.rect_h = (r < 2) ? 16'd0 : (r < 15) ? 16'($urandom_range(1, 40)) : 16'($urandom);
        return a;
    endfunction

    // Works out the answer for a request and queues both for the sender.
    task automatic post_request(logic [1:0] kind, logic [7:0] origin, logic [31:0] tag,
                                t_area area);
        t_request rq;
        rq.kind              = kind;
        rq.data              = '0;
        rq.data.origin_id    = origin;
        rq.data.msg_tag      = tag;
        rq.data.area         = area;
        rq.answer            = resolve_request(kind, rq.data);
        rq.hold_for_idle     = hold_next_for_idle;
        hold_next_for_idle   = 1'b0;
        request_backlog.push_back(rq);
        if (kind != REQ_UNUSED) begin
            posted_reqs++;
        end
    endtask

    // A request from someone else: it must be checked against every queued area.
    task automatic post_remote_check();
        post_request(REQ_CHECK, 8'($urandom), $urandom, random_area());
    endtask

    // Our own oldest operation coming back, as a well-formed echo would.
    task automatic post_echo();
        if (local_ops.size() == 0) begin
            post_remote_check();
        end else begin
            post_request(REQ_CHECK, local_ops[0].origin, local_ops[0].tag, random_area());
        end
    endtask

    // Stimulus: a directed opening, then random phases until enough requests exist.
    initial begin
        int    phase_len;
        int    r;
        int    own_origin;
        t_area big_pix;

        // Directed part. The first three exercise an empty queue.
        post_request(REQ_CHECK, 8'd5, 32'd1, area_of(DOM_PIX, 0, 0, 0, 4, 4));
        post_request(REQ_CLEAR, 8'd0, 32'd0, area_of(DOM_ALL, 0, 0, 0, 0, 0));
        post_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF,
                     area_of(3'd7, 16'hFFFF, -1, -1, 16'hFFFF, 16'hFFFF));

        // Three queued entries with extreme fields: the widest possible pixel
        // rectangle, a one-pixel-sized other-domain area, and an attribute area.
        big_pix = area_of(DOM_PIX, 16'hFFFF, -32768, -32768, 16'hFFFF, 16'hFFFF);
        post_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, big_pix);
        post_request(REQ_ADD, 8'h00, 32'h0000_0000, area_of(3'd7, 0, 32767, 32767, 1, 1));
        post_request(REQ_ADD, 8'h01, 32'h0000_0001, area_of(DOM_ATTR, 5, 0, 0, 1, 1));

        // Remote checks covering each conflict rule.
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_PIX, 16'hFFFF, 0, 0, 4, 4));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_PIX, 16'hFFFF, 0, 0, 0, 4));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_PIX, 16'hFFFF, 0, 0, 4, 0));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_ALL, 0, 0, 0, 1, 1));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_ATTR, 5, 0, 0, 1, 1));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(3'd7, 0, 0, 0, 1, 1));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(3'd7, 1, 0, 0, 1, 1));
        // Rectangles that only touch at the right edge do not overlap.
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_PIX, 16'hFFFF, 32767, 0, 1, 1));
        post_request(REQ_CHECK, 8'd9, 32'd9, area_of(DOM_PIX, 16'hFFFF, 32766, 0, 1, 1));

        // Echo of the head, then an echo with the wrong tag.
        post_request(REQ_CHECK, 8'hFF, 32'hFFFF_FFFF, area_of(DOM_PIX, 0, 0, 0, 1, 1));
        post_request(REQ_CHECK, 8'h00, 32'h0000_0001, area_of(DOM_PIX, 0, 0, 0, 1, 1));

        // A queued "everything" area blocks any remote operation; clear ends it.
        post_request(REQ_ADD, 8'd3, 32'd7, area_of(DOM_ALL, 0, 0, 0, 0, 0));
        post_request(REQ_CHECK, 8'd4, 32'd7, area_of(3'd3, 9, 0, 0, 1, 1));
        post_request(REQ_CLEAR, 8'd0, 32'd0, area_of(DOM_ALL, 0, 0, 0, 0, 0));

        // The first random phase starts only once the block has gone idle.
        hold_next_for_idle = 1'b1;
        while (posted_reqs < 1800) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // Fill the queue to the brim, run deep checks, overflow it and
                // then let some of our own operations come back.
                own_origin = $urandom_range(0, 255);
                while (local_ops.size() < QUEUE_SLOTS) begin
                    if ($urandom_range(0, 9) == 0) begin
                        post_remote_check();
                    end else begin
                        post_request(REQ_ADD, 8'(own_origin), $urandom, random_area());
                    end
                end
                repeat ($urandom_range(1, 4)) begin
                    post_request(REQ_ADD, 8'(own_origin), $urandom, random_area());
                end
                repeat ($urandom_range(1, 3)) post_remote_check();
                repeat ($urandom_range(2, 10)) post_echo();
            end else if (r < 18) begin
                // Noise: any request code, any field values.
                repeat ($urandom_range(5, 15)) begin
                    post_request(2'($urandom), 8'($urandom), $urandom, t_area'({$urandom, $urandom,
                                 $urandom}));
                end
            end else begin
                // A normal session: our own operations go in and come back in
                // order, interleaved with operations from other users.
                own_origin = $urandom_range(0, 255);
                phase_len  = $urandom_range(10, 60);
                repeat (phase_len) begin
                    r = $urandom_range(0, 99);
                    if (r < 35) begin
                        post_request(REQ_ADD, 8'(own_origin), $urandom, random_area());
                    end else if (r < 60) begin
                        post_echo();
                    end else if (r < 63 && local_ops.size() != 0) begin
                        // Echo whose tag differs from the head in one bit.
                        post_request(REQ_CHECK, local_ops[0].origin,
                                     local_ops[0].tag ^ (32'd1 << $urandom_range(0, 31)),
                                     random_area());
                    end else if (r < 96) begin
                        post_remote_check();
                    end else if (r < 98) begin
                        post_request(REQ_CLEAR, 8'($urandom), $urandom, random_area());
                    end else begin
                        post_request(REQ_UNUSED, 8'($urandom), $urandom, random_area());
                    end
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                hold_next_for_idle = 1'b1;
            end
        end

        // Everything has been generated; wait for the sender and the block to drain.
        while (request_backlog.size() != 0 || expected_answers.size() != 0) begin
            @(posedge i_clk);
        end
        // A check can take a full queue walk, so leave room for a stray result.
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sender. A request stays on the bus until its transfer completes; between
    // transfers the sender idles in random gaps after bursts of random length.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_taken) begin
            // Still waiting for the block to take the current request.
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (request_backlog.size() == 0 ||
                     (request_backlog[0].hold_for_idle && expected_answers.size() != 0)) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= request_backlog[0].data;
            s_tuser  <= request_backlog[0].kind;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                // A third of the bursts run straight into the next one.
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver. It switches between always ready, coin-flip stalls and mostly
    // stalled, and once holds off for a long stretch while requests keep coming.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!held_once && accepted_reqs >= 400) begin
            held_once <= 1'b1;
            hold_left <= 500;
            m_tready  <= 1'b0;
        end else begin
            pattern_cycle <= pattern_cycle + 1;
            if (pattern_cycle % 128 == 0) begin
                ready_mode <= $urandom_range(0, 2);
            end
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic report_field(string field, int got, int want);
        if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result %0d: %s is %0d, expected %0d", result_count, field, got, want);
            end
        end
    endtask

    // Both handshakes are sampled at the rising edge. An accepted request moves
    // its answer into the expected store; each result transfer is checked
    // against the oldest expected answer.
    always @(posedge i_clk) begin
        t_answer want;
        req_taken = i_rst_n && s_tvalid && s_tready;
        if (req_taken) begin
            expected_answers.push_back(request_backlog[0].answer);
            void'(request_backlog.pop_front());
            accepted_reqs++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("result %0d arrived with nothing expected: %h", result_count, m_tdata);
                end
            end else begin
                want = expected_answers.pop_front();
                report_field("action", m_tdata.action, want.action);
                report_field("dropped", m_tdata.dropped, want.dropped);
                report_field("pending_count", m_tdata.pending_count, want.pending_count);
            end
            result_count++;
        end
    end

endmodule
